/* src/avs_pkg.sv */
`timescale 1ns / 1ps

package avs_pkg;

  localparam int unsigned TDataInW  = 32;
  localparam int unsigned TDataOutW = 32;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned BaseW     = 7;
  localparam int unsigned TorqueW   = 15;

  localparam logic [CfgIdxW-1:0] CfgDriveBase = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgRegenBase = 4'd1;

  localparam logic [BaseW-1:0] DriveBaseRst = 7'd50;
  localparam logic [BaseW-1:0] RegenBaseRst = 7'd40;

  typedef struct packed {
    logic [3:0]         kind;
    logic               estop;
    logic               switch_forward;
    logic               go_button;
    logic [2:0]         unit_state;
    logic [2:0]         mission_code;
    logic               brake_armed_flag;
    logic signed [15:0] acceleration;
    logic               steering_fault;
    logic [1:0]         shutdown_request;
  } ev_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic [2:0]         sys_state;
    logic [1:0]         mission_status;
    logic [1:0]         mission_ind;
    logic [1:0]         brake_status;
    logic [TorqueW-1:0] torque_request;
    logic               remote_restart;
    logic               drive_reset;
  } res_t;

endpackage

/* src/autonomous_vehicle_supervisor_fsm.sv */
`timescale 1ns / 1ps

// Safety supervisor for a driverless vehicle.
// Input stream (s_axis): one event per beat. tuser carries the event kind,
// tdata the event payload. Output stream (m_axis): one status beat per event,
// carrying mode, AS state, mission, AMI, brake status, torque request and the
// remote-restart and drive-reset pulses.
// Config channel (cfg_*): register 0 drive torque base, register 1 regen
// torque base, 7 bits each; always ready. Write only while no event is in
// flight.
// Path from input beat to output beat: input register, mode logic, result
// register. Throughput: one event per cycle while the output is not stalled;
// the mode step and the torque multiply both fit between the two registers.
// Reset: mode start, AS off, all remembered inputs cleared, bases 50 and 40,
// no beats pending.
// Stall: when m_axis_tready is low the result register holds its beat; the
// input register still takes one more event, then s_axis_tready drops until
// the output beat is taken.

module autonomous_vehicle_supervisor_fsm (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] estop, [1] switch_forward, [2] go_button, [5:3] unit_state,
  // [8:6] mission_code, [9] brake_armed_flag, [25:10] acceleration,
  // [26] steering_fault, [28:27] shutdown_request, [31:29] zero
  input  logic [avs_pkg::TDataInW-1:0]   s_axis_tdata,
  // [3:0] kind
  input  logic [3:0]                     s_axis_tuser,

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [3:0] mode, [6:4] sys_state, [8:7] mission_status, [10:9] mission_ind,
  // [12:11] brake_status, [27:13] torque_request, [28] remote_restart,
  // [29] drive_reset, [31:30] zero
  output logic [avs_pkg::TDataOutW-1:0]  m_axis_tdata,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [avs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [avs_pkg::BaseW-1:0]      cfg_data_i
);

  avs_pkg::ev_t                  ev_q;
  logic                          in_vld_q;
  avs_pkg::res_t                 out_q;
  logic                          out_vld_q;
  logic [avs_pkg::BaseW-1:0]     drive_base_q;
  logic [avs_pkg::BaseW-1:0]     regen_base_q;

  avs_pkg::ev_t                  ev_in;
  avs_pkg::res_t                 res;
  logic [avs_pkg::TorqueW-1:0]   torque;
  logic                          advance;
  logic                          in_fire;

  assign ev_in.kind             = s_axis_tuser;
  assign ev_in.estop            = s_axis_tdata[0];
  assign ev_in.switch_forward   = s_axis_tdata[1];
  assign ev_in.go_button        = s_axis_tdata[2];
  assign ev_in.unit_state       = s_axis_tdata[5:3];
  assign ev_in.mission_code     = s_axis_tdata[8:6];
  assign ev_in.brake_armed_flag = s_axis_tdata[9];
  assign ev_in.acceleration     = $signed(s_axis_tdata[25:10]);
  assign ev_in.steering_fault   = s_axis_tdata[26];
  assign ev_in.shutdown_request = s_axis_tdata[28:27];

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  avs_torque u_torque (
    .accel_i      (ev_q.acceleration),
    .drive_base_i (drive_base_q),
    .regen_base_i (regen_base_q),
    .torque_o     (torque)
  );

  avs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .ev_i     (ev_q),
    .torque_i (torque),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      drive_base_q <= avs_pkg::DriveBaseRst;
      regen_base_q <= avs_pkg::RegenBaseRst;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_index_i == avs_pkg::CfgDriveBase) begin
        drive_base_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == avs_pkg::CfgRegenBase) begin
        regen_base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q <= ev_in;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.drive_reset, out_q.remote_restart,
                          out_q.torque_request, out_q.brake_status,
                          out_q.mission_ind, out_q.mission_status,
                          out_q.sys_state, out_q.mode};

endmodule

/* src/avs_torque.sv */
`timescale 1ns / 1ps

module avs_torque (
  input  logic signed [15:0]               accel_i,
  input  logic [avs_pkg::BaseW-1:0]        drive_base_i,
  input  logic [avs_pkg::BaseW-1:0]        regen_base_i,
  output logic [avs_pkg::TorqueW-1:0]      torque_o
);

  localparam logic signed [15:0] AccMax = 16'sd16384;
  localparam logic signed [15:0] AccMin = -16'sd16384;
  localparam logic [15:0]        AccOne = 16'd16384;
  localparam logic [16:0]        TrqMax = 17'd32767;

  logic signed [15:0]          acc_sat;
  logic [15:0]                 span;
  logic [avs_pkg::BaseW-1:0]   base;
  logic [22:0]                 prod;
  logic [16:0]                 scaled;

  always_comb begin
    if (accel_i > AccMax) begin
      acc_sat = AccMax;
    end else if (accel_i < AccMin) begin
      acc_sat = AccMin;
    end else begin
      acc_sat = accel_i;
    end
    // 1.0 + a lies in 0..2.0, fits unsigned 16 bits
    span   = $unsigned(acc_sat) + AccOne;
    base   = acc_sat[15] ? regen_base_i : drive_base_i;
    prod   = 23'(base) * 23'(span);
    scaled = prod[22:6];
    torque_o = (scaled > TrqMax) ? TrqMax[14:0] : scaled[14:0];
  end

endmodule

/* src/avs_core.sv */
`timescale 1ns / 1ps

module avs_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  avs_pkg::ev_t                  ev_i,
  input  logic [avs_pkg::TorqueW-1:0]   torque_i,
  output avs_pkg::res_t                 res_o
);

  typedef enum logic [3:0] {
    M_START     = 4'd0,
    M_SELECT    = 4'd1,
    M_WAIT      = 4'd2,
    M_CHECK     = 4'd3,
    M_READY     = 4'd4,
    M_RELEASE   = 4'd5,
    M_DRIVING   = 4'd6,
    M_ACTIVATE  = 4'd7,
    M_FINISHED  = 4'd8,
    M_EMERGENCY = 4'd9
  } mode_e;

  localparam logic [3:0] KindRemote   = 4'd0;
  localparam logic [3:0] KindAlive    = 4'd1;
  localparam logic [3:0] KindBrake    = 4'd2;
  localparam logic [3:0] KindCtrl     = 4'd3;
  localparam logic [3:0] KindWheel    = 4'd4;
  localparam logic [3:0] KindSteer    = 4'd5;
  localparam logic [3:0] KindAccel    = 4'd6;
  localparam logic [3:0] KindShutdown = 4'd7;
  localparam logic [3:0] KindMission  = 4'd8;

  localparam logic [2:0] AsOff     = 3'd0;
  localparam logic [2:0] AsReady   = 3'd1;
  localparam logic [2:0] AsDriving = 3'd2;
  localparam logic [2:0] AsFinish  = 3'd3;
  localparam logic [2:0] AsEbrake  = 3'd4;

  localparam logic [2:0] BuReady    = 3'd1;
  localparam logic [2:0] BuDrive    = 3'd2;
  localparam logic [2:0] BuBraking  = 3'd3;
  localparam logic [2:0] BuShutdown = 3'd4;

  localparam logic [1:0] WuOther  = 2'd0;
  localparam logic [1:0] WuSelect = 2'd1;
  localparam logic [1:0] WuAck    = 2'd2;

  localparam logic [2:0] MisNone       = 3'd0;
  localparam logic [2:0] MisManual     = 3'd1;
  localparam logic [2:0] MisInspection = 3'd2;
  localparam logic [2:0] MisBrakeTest  = 3'd3;
  localparam logic [2:0] MisTrackdrive = 3'd4;

  localparam logic [1:0] MsNone   = 2'd0;
  localparam logic [1:0] MsManual = 2'd1;
  localparam logic [1:0] MsAuto   = 2'd2;

  localparam logic [1:0] AmiNone       = 2'd0;
  localparam logic [1:0] AmiInspection = 2'd1;
  localparam logic [1:0] AmiBrakeTest  = 2'd2;
  localparam logic [1:0] AmiTrackdrive = 2'd3;

  localparam logic [1:0] BsArmed  = 2'd1;
  localparam logic [1:0] BsActive = 2'd2;

  localparam logic [1:0] SdEmergency = 2'd1;
  localparam logic [1:0] SdBrake     = 2'd2;
  localparam logic [1:0] SdFinished  = 2'd3;

  mode_e                        mode_q, mode_d;
  logic                         estop_q, estop_d;
  logic                         sw_q, sw_d;
  logic                         btn_q, btn_d;
  logic                         alive_q, alive_d;
  logic [2:0]                   bu_q, bu_d;
  logic [1:0]                   wu_q, wu_d;
  logic [2:0]                   wm_q, wm_d;
  logic [2:0]                   chosen_q, chosen_d;
  logic [1:0]                   mst_q, mst_d;
  logic [1:0]                   ami_q, ami_d;
  logic [2:0]                   as_q, as_d;
  logic [1:0]                   bst_q, bst_d;
  logic [avs_pkg::TorqueW-1:0]  held_q, held_d;

  logic                         run;
  logic                         restart;
  logic                         pulse;
  logic [avs_pkg::TorqueW-1:0]  trq;

  function automatic logic [1:0] ami_of(logic [2:0] m);
    logic [1:0] a;
    case (m)
      MisInspection: a = AmiInspection;
      MisBrakeTest:  a = AmiBrakeTest;
      MisTrackdrive: a = AmiTrackdrive;
      default:       a = AmiNone;
    endcase
    return a;
  endfunction

  always_comb begin
    mode_d   = mode_q;
    estop_d  = estop_q;
    sw_d     = sw_q;
    btn_d    = btn_q;
    alive_d  = alive_q;
    bu_d     = bu_q;
    wu_d     = wu_q;
    wm_d     = wm_q;
    chosen_d = chosen_q;
    mst_d    = mst_q;
    ami_d    = ami_q;
    as_d     = as_q;
    bst_d    = bst_q;
    held_d   = held_q;
    run      = 1'b1;
    restart  = 1'b0;
    pulse    = 1'b0;
    trq      = '0;

    case (ev_i.kind)
      KindRemote: begin
        alive_d = 1'b1;
        estop_d = ev_i.estop;
        sw_d    = ev_i.switch_forward;
        btn_d   = ev_i.go_button;
      end
      KindAlive: begin
        if (!alive_q) begin
          mode_d  = M_EMERGENCY;
          restart = 1'b1;
        end
        alive_d = 1'b0;
      end
      KindBrake: begin
        bu_d  = ev_i.unit_state;
        bst_d = ev_i.brake_armed_flag ? BsArmed : BsActive;
      end
      KindCtrl: begin
        run = 1'b1;
      end
      KindWheel: begin
        wu_d = (ev_i.unit_state <= 3'(WuAck)) ? ev_i.unit_state[1:0] : WuOther;
        wm_d = ev_i.mission_code;
      end
      KindSteer: begin
        if (ev_i.steering_fault) mode_d = M_EMERGENCY;
      end
      KindAccel: begin
        held_d = torque_i;
      end
      KindShutdown: begin
        case (ev_i.shutdown_request)
          SdEmergency: mode_d = M_EMERGENCY;
          SdBrake:     mode_d = M_ACTIVATE;
          SdFinished:  mode_d = M_FINISHED;
          default:     run = 1'b0;
        endcase
      end
      KindMission: begin
        chosen_d = ev_i.mission_code;
      end
      default: begin
        run = 1'b0;
      end
    endcase

    if (run) begin
      // modes evaluated in order, transitions may chain in one step
      if (mode_d == M_START) begin
        as_d     = AsOff;
        chosen_d = MisNone;
        mst_d    = MsNone;
        if (!sw_d) mode_d = M_SELECT;
      end
      if (mode_d == M_SELECT) begin
        as_d = AsOff;
        if (wu_d == WuSelect) mode_d = M_WAIT;
      end
      if (mode_d == M_WAIT) begin
        as_d = AsOff;
        if (wu_d == WuAck) chosen_d = wm_d;
        if (chosen_d != MisNone) begin
          ami_d  = ami_of(chosen_d);
          mode_d = M_CHECK;
          mst_d  = (chosen_d == MisManual) ? MsManual : MsAuto;
        end
      end
      if (mode_d == M_CHECK) begin
        as_d = AsOff;
        if (bu_d == BuReady && sw_d) mode_d = M_READY;
      end
      if (mode_d == M_READY) begin
        as_d = AsReady;
        if (btn_d) mode_d = M_RELEASE;
        if (bu_d == BuShutdown) mode_d = M_EMERGENCY;
      end
      if (mode_d == M_RELEASE) begin
        as_d = AsDriving;
        if (bu_d == BuDrive) begin
          mode_d = M_DRIVING;
          pulse  = 1'b1;
        end
        if (bu_d == BuShutdown) mode_d = M_EMERGENCY;
      end
      if (mode_d == M_DRIVING) begin
        as_d = AsDriving;
        trq  = held_d;
        if (bu_d == BuShutdown) mode_d = M_EMERGENCY;
      end
      if (mode_d == M_ACTIVATE) begin
        as_d = AsFinish;
        if (bu_d == BuBraking) mode_d = M_FINISHED;
      end
      if (mode_d == M_FINISHED) begin
        as_d = AsFinish;
        trq  = '0;
        if (!sw_d) mode_d = M_START;
      end
      if (mode_d == M_EMERGENCY) begin
        as_d = AsEbrake;
        trq  = '0;
        if (!estop_d && !sw_d) mode_d = M_START;
      end
      if (estop_d) begin
        trq    = '0;
        mode_d = M_EMERGENCY;
      end
    end else begin
      trq = (mode_d == M_DRIVING) ? held_d : '0;
    end

    res_o.mode           = mode_d;
    res_o.sys_state      = as_d;
    res_o.mission_status = mst_d;
    res_o.mission_ind    = ami_d;
    res_o.brake_status   = bst_d;
    res_o.torque_request = trq;
    res_o.remote_restart = restart;
    res_o.drive_reset    = pulse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_START;
      estop_q  <= 1'b0;
      sw_q     <= 1'b0;
      btn_q    <= 1'b0;
      alive_q  <= 1'b0;
      bu_q     <= '0;
      wu_q     <= WuOther;
      wm_q     <= MisNone;
      chosen_q <= MisNone;
      mst_q    <= MsNone;
      ami_q    <= AmiNone;
      as_q     <= AsOff;
      bst_q    <= '0;
      held_q   <= '0;
    end else if (en_i) begin
      mode_q   <= mode_d;
      estop_q  <= estop_d;
      sw_q     <= sw_d;
      btn_q    <= btn_d;
      alive_q  <= alive_d;
      bu_q     <= bu_d;
      wu_q     <= wu_d;
      wm_q     <= wm_d;
      chosen_q <= chosen_d;
      mst_q    <= mst_d;
      ami_q    <= ami_d;
      as_q     <= as_d;
      bst_q    <= bst_d;
      held_q   <= held_d;
    end
  end

  a_estop_forces_emergency: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    estop_q |-> mode_q == M_EMERGENCY
  ) else $error("stored e-stop without emergency mode");

  a_torque_only_driving: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.torque_request != '0 |-> mode_d == M_DRIVING
  ) else $error("torque requested outside driving mode");

  a_drive_reset_mode: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.drive_reset |-> mode_d == M_DRIVING || mode_d == M_EMERGENCY
  ) else $error("drive reset pulse in wrong mode");

  a_restart_from_tick: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.remote_restart |-> ev_i.kind == KindAlive && !alive_q
  ) else $error("remote restart without silent alive tick");

endmodule

/* verif/autonomous_vehicle_supervisor_fsm_test.sv */
`timescale 1ns / 1ps

module autonomous_vehicle_supervisor_fsm_test;

  // event kinds
  localparam logic [3:0] KRemote    = 4'd0;
  localparam logic [3:0] KAlive     = 4'd1;
  localparam logic [3:0] KBrakeHb   = 4'd2;
  localparam logic [3:0] KCtrlHb    = 4'd3;
  localparam logic [3:0] KWheelHb   = 4'd4;
  localparam logic [3:0] KSteer     = 4'd5;
  localparam logic [3:0] KAccel     = 4'd6;
  localparam logic [3:0] KShutdown  = 4'd7;
  localparam logic [3:0] KMission   = 4'd8;
  localparam logic [3:0] KSpareLo   = 4'd9;
  localparam logic [3:0] KSpareHi   = 4'd15;

  localparam logic [3:0] MStart     = 4'd0;
  localparam logic [3:0] MSelect    = 4'd1;
  localparam logic [3:0] MWait      = 4'd2;
  localparam logic [3:0] MCheck     = 4'd3;
  localparam logic [3:0] MReady     = 4'd4;
  localparam logic [3:0] MRelease   = 4'd5;
  localparam logic [3:0] MDriving   = 4'd6;
  localparam logic [3:0] MActivate  = 4'd7;
  localparam logic [3:0] MFinished  = 4'd8;
  localparam logic [3:0] MEmergency = 4'd9;

  localparam logic [2:0] AsOff      = 3'd0;
  localparam logic [2:0] AsReady    = 3'd1;
  localparam logic [2:0] AsDriving  = 3'd2;
  localparam logic [2:0] AsFinish   = 3'd3;
  localparam logic [2:0] AsEbrake   = 3'd4;

  localparam logic [2:0] BuOther    = 3'd0;
  localparam logic [2:0] BuReady    = 3'd1;
  localparam logic [2:0] BuDrive    = 3'd2;
  localparam logic [2:0] BuBraking  = 3'd3;
  localparam logic [2:0] BuShutdown = 3'd4;
  localparam logic [2:0] BuSpareHi  = 3'd7;

  localparam logic [2:0] WuOther    = 3'd0;
  localparam logic [2:0] WuSelect   = 3'd1;
  localparam logic [2:0] WuAck      = 3'd2;
  localparam logic [2:0] WuSpare    = 3'd5;

  localparam logic [1:0] SdNone     = 2'd0;
  localparam logic [1:0] SdEmerg    = 2'd1;
  localparam logic [1:0] SdBrake    = 2'd2;
  localparam logic [1:0] SdFinished = 2'd3;

  localparam logic [2:0] MsnNone    = 3'd0;
  localparam logic [2:0] MsnManual  = 3'd1;
  localparam logic [2:0] MsnInspect = 3'd2;
  localparam logic [2:0] MsnBrkTest = 3'd3;
  localparam logic [2:0] MsnTrack   = 3'd4;

  localparam logic [1:0] MstNone    = 2'd0;
  localparam logic [1:0] MstManual  = 2'd1;
  localparam logic [1:0] MstAuto    = 2'd2;

  localparam logic [1:0] AmiNone    = 2'd0;
  localparam logic [1:0] AmiInspect = 2'd1;
  localparam logic [1:0] AmiBrkTest = 2'd2;
  localparam logic [1:0] AmiTrack   = 2'd3;

  localparam logic [1:0] BsUnavail  = 2'd0;
  localparam logic [1:0] BsArmed    = 2'd1;
  localparam logic [1:0] BsActive   = 2'd2;

  localparam logic [avs_pkg::CfgIdxW-1:0] CfgSpareIdx = 4'd15;

  localparam int PhaseItems = 240;
  localparam int NumPhases  = 6;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [avs_pkg::TDataInW-1:0]  s_axis_tdata = '0;
  logic [3:0]                    s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [avs_pkg::TDataOutW-1:0] m_axis_tdata;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [avs_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [avs_pkg::BaseW-1:0]     cfg_data_i = '0;

  autonomous_vehicle_supervisor_fsm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // supervisor shadow state
  logic [avs_pkg::BaseW-1:0]   drive_base = avs_pkg::DriveBaseRst;
  logic [avs_pkg::BaseW-1:0]   regen_base = avs_pkg::RegenBaseRst;
  logic [3:0]                  sv_mode = MStart;
  logic                        rm_estop = 1'b0;
  logic                        rm_switch = 1'b0;
  logic                        rm_button = 1'b0;
  logic                        rm_alive = 1'b0;
  logic [2:0]                  brake_unit = BuOther;
  logic [2:0]                  wheel_unit = WuOther;
  logic [2:0]                  wheel_mission = MsnNone;
  logic [2:0]                  mission_pick = MsnNone;
  logic [1:0]                  mission_stat = MstNone;
  logic [1:0]                  ami_code = AmiNone;
  logic [2:0]                  as_code = AsOff;
  logic [1:0]                  brake_stat = BsUnavail;
  logic [avs_pkg::TorqueW-1:0] torque_held = '0;

  avs_pkg::ev_t  pending_events[$];
  avs_pkg::res_t expected_status[$];
  avs_pkg::ev_t  ev_on_bus;

  bit ev_taken, res_taken;
  bit src_calm, sink_calm;
  int src_hold, sink_hold;
  int n_counted, n_events, n_checked, n_cfg_writes, err_count;
  int mode_hits[16];

  function automatic avs_pkg::res_t predict_status(avs_pkg::ev_t ev);
    avs_pkg::res_t               r;
    logic [avs_pkg::TorqueW-1:0] trq;
    logic                        pulse, restart;
    bit                          run_fsm;
    int                          a, base, t;
    trq = '0;
    pulse = 1'b0;
    restart = 1'b0;
    run_fsm = 1'b1;
    case (ev.kind)
      KRemote: begin
        rm_alive = 1'b1;
        rm_estop = ev.estop;
        rm_switch = ev.switch_forward;
        rm_button = ev.go_button;
      end
      KAlive: begin
        if (!rm_alive) begin
          sv_mode = MEmergency;
          restart = 1'b1;
        end
        rm_alive = 1'b0;
      end
      KBrakeHb: begin
        brake_unit = ev.unit_state;
        brake_stat = ev.brake_armed_flag ? BsArmed : BsActive;
      end
      KCtrlHb: ;
      KWheelHb: begin
        wheel_unit = (ev.unit_state <= WuAck) ? ev.unit_state : WuOther;
        wheel_mission = ev.mission_code;
      end
      KSteer: if (ev.steering_fault) sv_mode = MEmergency;
      KAccel: begin
        a = $signed(ev.acceleration);
        if (a > 16384) a = 16384;
        if (a < -16384) a = -16384;
        base = (a >= 0) ? int'(drive_base) : int'(regen_base);
        t = (base * (16384 + a)) >>> 6;
        torque_held = (t > 32767) ? 15'h7FFF : t[avs_pkg::TorqueW-1:0];
      end
      KShutdown: begin
        case (ev.shutdown_request)
          SdEmerg:    sv_mode = MEmergency;
          SdBrake:    sv_mode = MActivate;
          SdFinished: sv_mode = MFinished;
          default:    run_fsm = 1'b0;
        endcase
      end
      KMission: mission_pick = ev.mission_code;
      default: run_fsm = 1'b0;
    endcase

    if (run_fsm) begin
      if (sv_mode == MStart) begin
        as_code = AsOff;
        mission_pick = MsnNone;
        mission_stat = MstNone;
        if (!rm_switch) sv_mode = MSelect;
      end
      if (sv_mode == MSelect) begin
        as_code = AsOff;
        if (wheel_unit == WuSelect) sv_mode = MWait;
      end
      if (sv_mode == MWait) begin
        as_code = AsOff;
        if (wheel_unit == WuAck) mission_pick = wheel_mission;
        if (mission_pick != MsnNone) begin
          case (mission_pick)
            MsnInspect: ami_code = AmiInspect;
            MsnBrkTest: ami_code = AmiBrkTest;
            MsnTrack:   ami_code = AmiTrack;
            default:    ami_code = AmiNone;
          endcase
          sv_mode = MCheck;
          mission_stat = (mission_pick == MsnManual) ? MstManual : MstAuto;
        end
      end
      if (sv_mode == MCheck) begin
        as_code = AsOff;
        if (brake_unit == BuReady && rm_switch) sv_mode = MReady;
      end
      if (sv_mode == MReady) begin
        as_code = AsReady;
        if (rm_button) sv_mode = MRelease;
        if (brake_unit == BuShutdown) sv_mode = MEmergency;
      end
      if (sv_mode == MRelease) begin
        as_code = AsDriving;
        if (brake_unit == BuDrive) begin
          sv_mode = MDriving;
          pulse = 1'b1;
        end
        if (brake_unit == BuShutdown) sv_mode = MEmergency;
      end
      if (sv_mode == MDriving) begin
        as_code = AsDriving;
        trq = torque_held;
        if (brake_unit == BuShutdown) sv_mode = MEmergency;
      end
      if (sv_mode == MActivate) begin
        as_code = AsFinish;
        if (brake_unit == BuBraking) sv_mode = MFinished;
      end
      if (sv_mode == MFinished) begin
        as_code = AsFinish;
        trq = '0;
        if (!rm_switch) sv_mode = MStart;
      end
      if (sv_mode == MEmergency) begin
        as_code = AsEbrake;
        trq = '0;
        if (!rm_estop && !rm_switch) sv_mode = MStart;
      end
      if (rm_estop) begin
        trq = '0;
        sv_mode = MEmergency;
      end
    end else begin
      trq = (sv_mode == MDriving) ? torque_held : '0;
    end

    r.mode = sv_mode;
    r.sys_state = as_code;
    r.mission_status = mission_stat;
    r.mission_ind = ami_code;
    r.brake_status = brake_stat;
    r.torque_request = trq;
    r.remote_restart = restart;
    r.drive_reset = pulse;
    return r;
  endfunction

  function automatic avs_pkg::res_t status_of(logic [avs_pkg::TDataOutW-1:0] w);
    avs_pkg::res_t r;
    r.mode = w[3:0];
    r.sys_state = w[6:4];
    r.mission_status = w[8:7];
    r.mission_ind = w[10:9];
    r.brake_status = w[12:11];
    r.torque_request = w[27:13];
    r.remote_restart = w[28];
    r.drive_reset = w[29];
    return r;
  endfunction

  function automatic int pick_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic avs_pkg::ev_t rand_ev();
    avs_pkg::ev_t e;
    e.kind = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
    e.estop = 1'($urandom);
    e.switch_forward = 1'($urandom);
    e.go_button = 1'($urandom);
    e.unit_state = 3'($urandom);
    e.mission_code = 3'($urandom);
    e.brake_armed_flag = 1'($urandom);
    e.acceleration = 16'($urandom);
    e.steering_fault = 1'($urandom);
    e.shutdown_request = 2'($urandom);
    return e;
  endfunction

  function automatic avs_pkg::ev_t ev_kind(logic [3:0] k);
    avs_pkg::ev_t e;
    e = rand_ev();
    e.kind = k;
    return e;
  endfunction

  function automatic avs_pkg::ev_t ev_remote(bit es, bit sw, bit btn);
    avs_pkg::ev_t e;
    e = ev_kind(KRemote);
    e.estop = es;
    e.switch_forward = sw;
    e.go_button = btn;
    return e;
  endfunction

  function automatic avs_pkg::ev_t ev_brake(logic [2:0] unit, bit armed);
    avs_pkg::ev_t e;
    e = ev_kind(KBrakeHb);
    e.unit_state = unit;
    e.brake_armed_flag = armed;
    return e;
  endfunction

  function automatic avs_pkg::ev_t ev_wheel(logic [2:0] unit, logic [2:0] msn);
    avs_pkg::ev_t e;
    e = ev_kind(KWheelHb);
    e.unit_state = unit;
    e.mission_code = msn;
    return e;
  endfunction

  function automatic avs_pkg::ev_t ev_accel(int a);
    avs_pkg::ev_t e;
    e = ev_kind(KAccel);
    e.acceleration = 16'(a);
    return e;
  endfunction

  function automatic avs_pkg::ev_t ev_steer(bit f);
    avs_pkg::ev_t e;
    e = ev_kind(KSteer);
    e.steering_fault = f;
    return e;
  endfunction

  function automatic avs_pkg::ev_t ev_shut(logic [1:0] req);
    avs_pkg::ev_t e;
    e = ev_kind(KShutdown);
    e.shutdown_request = req;
    return e;
  endfunction

  function automatic avs_pkg::ev_t ev_mission(logic [2:0] msn);
    avs_pkg::ev_t e;
    e = ev_kind(KMission);
    e.mission_code = msn;
    return e;
  endfunction

  function automatic int rand_accel();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 7))
          0: return -32768;
          1: return 32767;
          2: return -16384;
          3: return 16384;
          4: return -16385;
          5: return 16385;
          6: return -1;
          default: return 0;
        endcase
      end
      1: return int'($urandom_range(0, 32768)) - 16384;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic push_ev(avs_pkg::ev_t e);
    pending_events.push_back(e);
    if (e.kind <= KMission && !(e.kind == KShutdown && e.shutdown_request == SdNone))
      n_counted++;
  endtask

  // occasional noise ahead of a step, occasional dropped step
  task automatic add_step(avs_pkg::ev_t e);
    if ($urandom_range(0, 14) == 0) push_ev(rand_ev());
    if ($urandom_range(0, 39) != 0) push_ev(e);
  endtask

  task automatic queue_mission_run();
    logic [2:0] msn;
    msn = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    add_step(ev_remote(1'b0, 1'b0, 1'b0));
    add_step(ev_kind(KAlive));
    add_step(ev_wheel(WuSelect, 3'($urandom_range(0, 7))));
    if ($urandom_range(0, 2) == 0) add_step(ev_mission(msn));
    add_step(ev_wheel(WuAck, msn));
    add_step(ev_brake(BuReady, $urandom_range(0, 3) != 0));
    add_step(ev_remote(1'b0, 1'b1, 1'b0));
    repeat ($urandom_range(0, 2)) add_step(ev_accel(rand_accel()));
    add_step(ev_remote(1'b0, 1'b1, 1'b1));
    add_step(ev_kind(KAlive));
    add_step(ev_brake(BuDrive, 1'b1));
    repeat ($urandom_range(2, 10)) begin
      case ($urandom_range(0, 4))
        0, 1: add_step(ev_accel(rand_accel()));
        2: begin
          add_step(ev_remote(1'b0, 1'b1, 1'($urandom)));
          add_step(ev_kind(KAlive));
        end
        3: add_step(ev_kind(KCtrlHb));
        default: add_step(ev_brake(BuDrive, 1'($urandom)));
      endcase
    end
    case ($urandom_range(0, 6))
      0: begin
        add_step(ev_shut(SdBrake));
        add_step(ev_brake(BuBraking, 1'($urandom)));
      end
      1: add_step(ev_shut(SdFinished));
      2: add_step(ev_shut(SdEmerg));
      3: add_step(ev_brake(BuShutdown, 1'($urandom)));
      4: add_step(ev_remote(1'b1, 1'($urandom), 1'($urandom)));
      5: add_step(ev_steer(1'b1));
      default: begin
        add_step(ev_kind(KAlive));
        add_step(ev_kind(KAlive));
      end
    endcase
    add_step(ev_remote(1'b0, 1'b0, 1'b0));
  endtask

  task automatic write_base(logic [avs_pkg::CfgIdxW-1:0] idx,
                            logic [avs_pkg::BaseW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == avs_pkg::CfgDriveBase) drive_base = val;
    else if (idx == avs_pkg::CfgRegenBase) regen_base = val;
    n_cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || s_axis_tvalid || expected_status.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic log_failure(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR: %s", msg);
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // source side: one event per beat, random gap after each accepted beat
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ev_taken) begin
        if ($urandom_range(0, 19) == 0) src_calm = !src_calm;
        src_hold = pick_wait(src_calm);
      end
      if (!s_axis_tvalid || ev_taken) begin
        if (src_hold > 0) begin
          s_axis_tvalid <= 1'b0;
          src_hold--;
        end else if (pending_events.size() != 0) begin
          ev_on_bus = pending_events.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= ev_on_bus.kind;
          s_axis_tdata <= {3'b000, ev_on_bus.shutdown_request, ev_on_bus.steering_fault,
                           ev_on_bus.acceleration, ev_on_bus.brake_armed_flag,
                           ev_on_bus.mission_code, ev_on_bus.unit_state,
                           ev_on_bus.go_button, ev_on_bus.switch_forward, ev_on_bus.estop};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side: random stall after each accepted status beat
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
        sink_hold = pick_wait(sink_calm);
      end
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    avs_pkg::res_t exp_st, act_st;
    ev_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    res_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (ev_taken) begin
      expected_status.push_back(predict_status(ev_on_bus));
      n_events++;
    end
    if (res_taken) begin
      if (expected_status.size() == 0) begin
        log_failure($sformatf("status beat %h with no event outstanding", m_axis_tdata));
      end else begin
        exp_st = expected_status.pop_front();
        act_st = status_of(m_axis_tdata);
        n_checked++;
        mode_hits[exp_st.mode]++;
        if (act_st !== exp_st || m_axis_tdata[31:30] !== 2'b00)
          log_failure($sformatf({"beat %0d (exp/act): mode %0d/%0d as %0d/%0d mission %0d/%0d",
                                 " ami %0d/%0d brake %0d/%0d torque %0d/%0d restart %0d/%0d",
                                 " drive_reset %0d/%0d pad 0/%0d"},
                                n_checked, exp_st.mode, act_st.mode, exp_st.sys_state,
                                act_st.sys_state, exp_st.mission_status, act_st.mission_status,
                                exp_st.mission_ind, act_st.mission_ind, exp_st.brake_status,
                                act_st.brake_status, exp_st.torque_request,
                                act_st.torque_request, exp_st.remote_restart,
                                act_st.remote_restart, exp_st.drive_reset,
                                act_st.drive_reset, m_axis_tdata[31:30]));
      end
    end
  end

  initial begin
    int n_directed;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed walk through the main paths at reset torque settings
    push_ev(ev_kind(KAlive));
    push_ev(ev_remote(1'b1, 1'b1, 1'b1));
    push_ev(ev_remote(1'b0, 1'b0, 1'b0));
    push_ev(ev_kind(KCtrlHb));
    push_ev(ev_wheel(WuSpare, MsnTrack));
    push_ev(ev_wheel(WuSelect, MsnNone));
    push_ev(ev_wheel(WuAck, MsnTrack));
    push_ev(ev_brake(BuReady, 1'b0));
    push_ev(ev_brake(BuReady, 1'b1));
    push_ev(ev_remote(1'b0, 1'b1, 1'b0));
    push_ev(ev_kind(KAlive));
    push_ev(ev_accel(32767));
    push_ev(ev_remote(1'b0, 1'b1, 1'b1));
    push_ev(ev_brake(BuDrive, 1'b1));
    push_ev(ev_accel(-32768));
    push_ev(ev_accel(16385));
    push_ev(ev_accel(-1));
    push_ev(ev_kind(KSpareLo));
    push_ev(ev_shut(SdNone));
    push_ev(ev_steer(1'b0));
    push_ev(ev_shut(SdBrake));
    push_ev(ev_brake(BuSpareHi, 1'b1));
    push_ev(ev_brake(BuBraking, 1'b1));
    push_ev(ev_remote(1'b0, 1'b0, 1'b0));
    push_ev(ev_mission(MsnManual));
    push_ev(ev_shut(SdFinished));
    push_ev(ev_shut(SdEmerg));
    push_ev(ev_kind(KSpareHi));
    push_ev(ev_brake(BuShutdown, 1'b0));
    push_ev(ev_steer(1'b1));
    n_directed = n_counted;

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1: begin
          write_base(avs_pkg::CfgDriveBase, 7'd127);
          write_base(avs_pkg::CfgRegenBase, 7'd127);
        end
        2: begin
          write_base(avs_pkg::CfgDriveBase, 7'd0);
          write_base(avs_pkg::CfgRegenBase, 7'd0);
        end
        3: begin
          write_base(avs_pkg::CfgDriveBase, 7'd127);
          write_base(avs_pkg::CfgRegenBase, 7'd0);
          write_base(CfgSpareIdx, 7'($urandom));
        end
        4: begin
          write_base(avs_pkg::CfgDriveBase, 7'($urandom));
          write_base(avs_pkg::CfgRegenBase, 7'($urandom));
        end
        5: begin
          write_base(avs_pkg::CfgDriveBase, 7'd0);
          write_base(avs_pkg::CfgRegenBase, 7'd127);
        end
        default: ;
      endcase
      while (n_counted < n_directed + (p + 1) * PhaseItems) begin
        if ($urandom_range(0, 3) != 0) queue_mission_run();
        else repeat ($urandom_range(1, 8)) push_ev(rand_ev());
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("%0d events in, %0d status beats checked, %0d torque setting writes",
             n_events, n_checked, n_cfg_writes);
    $display("results in driving %0d, finished %0d, emergency %0d",
             mode_hits[MDriving], mode_hits[MFinished], mode_hits[MEmergency]);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
src/avs_pkg.sv
src/avs_torque.sv
src/avs_core.sv
src/autonomous_vehicle_supervisor_fsm.sv
verif/autonomous_vehicle_supervisor_fsm_test.sv
